// File: rtl/core/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants of the button gesture detector: event record,
// event kinds, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package bgd_pkg;

  // Default pin count; only the first eight pins are ever served.
  localparam int unsigned PIN_COUNT_DEF = 8;
  localparam int unsigned PIN_MAX       = 8;

  // Configuration register indexes.
  localparam logic [2:0] REG_WATCH_MASK   = 3'd0;
  localparam logic [2:0] REG_BUTTON_MASK  = 3'd1;
  localparam logic [2:0] REG_IDLE_LEVEL   = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE     = 3'd3;
  localparam logic [2:0] REG_CLICK_WINDOW = 3'd4;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd5;
  localparam logic [2:0] REG_REPEAT_START = 3'd6;
  localparam logic [2:0] REG_REPEAT_INTVL = 3'd7;

  // Register reset values.
  localparam logic [7:0]  IDLE_LEVEL_RST   = 8'hFF;
  localparam logic [15:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [15:0] CLICK_WINDOW_RST = 16'd400;
  localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [15:0] REPEAT_START_RST = 16'd2000;
  localparam logic [15:0] REPEAT_INTVL_RST = 16'd100;

  typedef enum logic [1:0] {
    EV_LEVEL  = 2'd0,
    EV_REPEAT = 2'd1,
    EV_LONG   = 2'd2,
    EV_CLICK  = 2'd3
  } bgd_kind_e;

  typedef struct packed {
    logic [2:0] pin;
    bgd_kind_e  kind;
    logic       level;
    logic [7:0] count;
  } bgd_evt_t;

  // Sequencer to output queue.
  typedef struct packed {
    logic push;
    logic flush;
  } bgd_oq_ctrl_t;

  // Output queue to sequencer.
  typedef struct packed {
    logic stall;
    logic hold_valid;
  } bgd_oq_stat_t;

  // Results of the shared subtract and compare unit.
  typedef struct packed {
    logic gt0;
    logic lt0;
    logic gt1;
    logic gt2;
  } bgd_cmp_t;

endpackage

// File: rtl/core/bgd_cmp_unit.sv
// ----------------------------------------------------------------------------
// bgd_cmp_unit
// Shared time unit: one wrapping 32-bit subtraction followed by compares of
// the difference against up to three 16-bit thresholds.
// ----------------------------------------------------------------------------
module bgd_cmp_unit (
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  input  logic [15:0]       thr0_i,
  input  logic [15:0]       thr1_i,
  input  logic [15:0]       thr2_i,
  output bgd_pkg::bgd_cmp_t res_o
);

  logic [31:0] diff;

  assign diff      = a_i - b_i;
  assign res_o.gt0 = diff > {16'd0, thr0_i};
  assign res_o.lt0 = diff < {16'd0, thr0_i};
  assign res_o.gt1 = diff > {16'd0, thr1_i};
  assign res_o.gt2 = diff > {16'd0, thr2_i};

endmodule

// File: rtl/core/bgd_evt_out.sv
// ----------------------------------------------------------------------------
// bgd_evt_out
// Event output queue: a hold stage keeps the newest event until it is known
// whether another follows, then passes it to the output register with the
// last flag set accordingly.
// ----------------------------------------------------------------------------
module bgd_evt_out (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bgd_pkg::bgd_oq_ctrl_t ctrl_i,
  input  bgd_pkg::bgd_evt_t     evt_i,
  output bgd_pkg::bgd_oq_stat_t stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bgd_pkg::bgd_evt_t     out_evt_o,
  output logic                  out_last_o
);

  bgd_pkg::bgd_evt_t hold_q, hold_d;
  logic              hold_valid_q, hold_valid_d;
  bgd_pkg::bgd_evt_t out_q, out_d;
  logic              out_last_q, out_last_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free          = !out_valid_q || out_ready_i;
  assign stat_o.stall      = hold_valid_q && !out_free;
  assign stat_o.hold_valid = hold_valid_q;

  always_comb begin
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (ctrl_i.push && !stat_o.stall) begin
      // A newer event exists, so the held one is not the last of the tick.
      if (hold_valid_q) begin
        out_d       = hold_q;
        out_last_d  = 1'b0;
        out_valid_d = 1'b1;
      end
      hold_d       = evt_i;
      hold_valid_d = 1'b1;
    end else if (ctrl_i.flush && hold_valid_q && out_free) begin
      out_d        = hold_q;
      out_last_d   = 1'b1;
      out_valid_d  = 1'b1;
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_evt_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

// File: rtl/core/button_gesture_detector_core.sv
// ----------------------------------------------------------------------------
// button_gesture_detector_core
// Debounces up to eight pins per millisecond tick and reports level changes,
// repeats, long presses and multi-clicks as a stream of events.
// ----------------------------------------------------------------------------
// Each accepted tick is worked through by a small sequencer around one shared
// 32-bit subtract and compare unit, in this order: the accepting step, the
// debounce check, sampling of each pin (only when the debounce timer has
// expired), the evaluation check, gesture evaluation of each pin (only when
// the evaluation interval has passed) and the closing step of the tick,
// which also passes on an event still held there. Events leave at most one
// per cycle through an output register while the receiver is ready, the
// final event of a tick carrying last_o, and the walk pauses while the
// output side is stalled. A tick that causes no event gives no output.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i;
// the user must do so only while the block is idle, which the block
// itself does not enforce.
// ----------------------------------------------------------------------------
module button_gesture_detector_core #(
  parameter int unsigned PIN_COUNT = bgd_pkg::PIN_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  pin_index_o,
  output logic [1:0]  event_kind_o,
  output logic        level_o,
  output logic [7:0]  press_count_o,
  output logic        last_o
);

  localparam int unsigned PINS = (PIN_COUNT < bgd_pkg::PIN_MAX) ? PIN_COUNT : bgd_pkg::PIN_MAX;
  localparam int unsigned IdxW = (PINS > 1) ? $clog2(PINS) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(PINS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DEB   = 3'd1;
  localparam logic [2:0] ST_LVL   = 3'd2;
  localparam logic [2:0] ST_EVC   = 3'd3;
  localparam logic [2:0] ST_EVL   = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  // Configuration registers.
  logic [7:0]  watch_q, button_q, idle_q;
  logic [15:0] debounce_q, click_q, long_q, rstart_q, rintvl_q;

  // Detector state.
  logic [PINS-1:0] deb_lvl_q;
  logic [PINS-1:0] pressed_q;
  logic [7:0]      tally_q [PINS];
  logic [31:0]     ptime_q [PINS];
  logic [7:0]      raw_prev_q;
  logic            pending_q;
  logic [31:0]     deb_start_q;
  logic [31:0]     last_eval_q;

  // Sequencer and latched tick.
  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q;
  logic [31:0]     now_q;
  logic [PINS-1:0] raw_q;
  logic            change_q;

  logic [PINS-1:0] watched;
  logic            in_fire;
  logic            change_now;

  logic [31:0]           cmp_b;
  logic [15:0]           cmp_thr0;
  bgd_pkg::bgd_cmp_t     cmp_res;

  bgd_pkg::bgd_oq_ctrl_t oq_ctrl;
  bgd_pkg::bgd_oq_stat_t oq_stat;
  bgd_pkg::bgd_evt_t     evt;
  bgd_pkg::bgd_evt_t     out_evt;

  // Per-pin views of the current step.
  logic       cur_raw, cur_deb, cur_idle, cur_pressed, cur_watch, cur_btn;
  logic [7:0] cur_tally;
  logic       lv_press;
  logic [7:0] lv_tally;
  logic       lv_event;
  logic [7:0] ev_tally;
  logic       ev_hit;
  bgd_pkg::bgd_kind_e ev_kind;
  logic [7:0] ev_count;

  assign watched    = watch_q[PINS-1:0];
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign change_now = |((pin_levels_i[PINS-1:0] ^ raw_prev_q[PINS-1:0]) & watched);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watch_q    <= 8'd0;
      button_q   <= 8'd0;
      idle_q     <= bgd_pkg::IDLE_LEVEL_RST;
      debounce_q <= bgd_pkg::DEBOUNCE_RST;
      click_q    <= bgd_pkg::CLICK_WINDOW_RST;
      long_q     <= bgd_pkg::LONG_PRESS_RST;
      rstart_q   <= bgd_pkg::REPEAT_START_RST;
      rintvl_q   <= bgd_pkg::REPEAT_INTVL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bgd_pkg::REG_WATCH_MASK:   watch_q    <= cfg_wdata_i[7:0];
        bgd_pkg::REG_BUTTON_MASK:  button_q   <= cfg_wdata_i[7:0];
        bgd_pkg::REG_IDLE_LEVEL:   idle_q     <= cfg_wdata_i[7:0];
        bgd_pkg::REG_DEBOUNCE:     debounce_q <= cfg_wdata_i;
        bgd_pkg::REG_CLICK_WINDOW: click_q    <= cfg_wdata_i;
        bgd_pkg::REG_LONG_PRESS:   long_q     <= cfg_wdata_i;
        bgd_pkg::REG_REPEAT_START: rstart_q   <= cfg_wdata_i;
        bgd_pkg::REG_REPEAT_INTVL: rintvl_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    case (state_q)
      ST_DEB: begin
        cmp_b    = deb_start_q;
        cmp_thr0 = debounce_q;
      end
      ST_EVC: begin
        cmp_b    = last_eval_q;
        cmp_thr0 = rintvl_q;
      end
      default: begin
        cmp_b    = ptime_q[idx_q];
        cmp_thr0 = rstart_q;
      end
    endcase
  end

  bgd_cmp_unit u_cmp (
    .a_i    (now_q),
    .b_i    (cmp_b),
    .thr0_i (cmp_thr0),
    .thr1_i (long_q),
    .thr2_i (click_q),
    .res_o  (cmp_res)
  );

  assign cur_raw     = raw_q[idx_q];
  assign cur_deb     = deb_lvl_q[idx_q];
  assign cur_idle    = idle_q[idx_q];
  assign cur_pressed = pressed_q[idx_q];
  assign cur_watch   = watched[idx_q];
  assign cur_btn     = button_q[idx_q];
  assign cur_tally   = tally_q[idx_q];

  // Sampling step of one pin.
  assign lv_event = cur_watch && (cur_raw != cur_deb);
  assign lv_press = (cur_raw != cur_idle);
  assign lv_tally = (lv_press && (cur_tally != 8'hFF)) ? cur_tally + 8'd1 : cur_tally;

  // Gesture step of one pin; the rules are exclusive, so at most one event.
  always_comb begin
    ev_tally = cur_tally;
    ev_hit   = 1'b0;
    ev_kind  = bgd_pkg::EV_REPEAT;
    ev_count = cur_tally;
    if (cmp_res.gt0) begin
      if (cur_pressed && (cur_tally == 8'd1)) begin
        ev_hit  = 1'b1;
        ev_kind = bgd_pkg::EV_REPEAT;
      end else begin
        ev_tally = 8'd0;
      end
    end
    if (cmp_res.gt1 && cmp_res.lt0 && !cur_pressed && (ev_tally == 8'd1)) begin
      ev_hit   = 1'b1;
      ev_kind  = bgd_pkg::EV_LONG;
      ev_count = ev_tally;
      ev_tally = 8'd0;
    end
    if (cmp_res.gt2 && !cur_pressed && (ev_tally != 8'd0)) begin
      ev_hit   = 1'b1;
      ev_kind  = bgd_pkg::EV_CLICK;
      ev_count = ev_tally;
      ev_tally = 8'd0;
    end
  end

  // Event assembly and queue control.
  always_comb begin
    evt.pin  = 3'(idx_q);
    oq_ctrl  = '0;
    if (state_q == ST_LVL) begin
      evt.kind     = bgd_pkg::EV_LEVEL;
      evt.level    = cur_raw;
      evt.count    = lv_tally;
      oq_ctrl.push = lv_event;
    end else begin
      evt.kind     = ev_kind;
      evt.level    = cur_deb;
      evt.count    = ev_count;
      oq_ctrl.push = (state_q == ST_EVL) && cur_watch && cur_btn && ev_hit;
    end
    oq_ctrl.flush = (state_q == ST_FLUSH);
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_DEB;
      ST_DEB: begin
        if (!change_q && pending_q && cmp_res.gt0) state_d = ST_LVL;
        else state_d = ST_EVC;
      end
      ST_LVL:   if (!oq_stat.stall && (idx_q == IdxLast)) state_d = ST_EVC;
      ST_EVC:   state_d = cmp_res.gt0 ? ST_EVL : ST_FLUSH;
      ST_EVL:   if (!oq_stat.stall && (idx_q == IdxLast)) state_d = ST_FLUSH;
      ST_FLUSH: if (!oq_stat.hold_valid) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      change_q    <= 1'b0;
      raw_prev_q  <= bgd_pkg::IDLE_LEVEL_RST;
      pending_q   <= 1'b0;
      deb_start_q <= 32'd0;
      last_eval_q <= 32'd0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        change_q   <= change_now;
        raw_prev_q <= pin_levels_i;
      end
      case (state_q)
        ST_DEB: begin
          idx_q <= '0;
          if (change_q) begin
            // A change restarts the timer, so no sampling in this tick.
            pending_q   <= 1'b1;
            deb_start_q <= now_q;
          end else if (pending_q && cmp_res.gt0) begin
            pending_q <= 1'b0;
          end
        end
        ST_EVC: begin
          idx_q <= '0;
          if (cmp_res.gt0) last_eval_q <= now_q;
        end
        ST_LVL, ST_EVL: begin
          if (!oq_stat.stall && (idx_q != IdxLast)) idx_q <= idx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Per-pin state, written at the pin the sequencer points to.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_lvl_q <= bgd_pkg::IDLE_LEVEL_RST[PINS-1:0];
      pressed_q <= '0;
      for (int i = 0; i < PINS; i++) begin
        tally_q[i] <= 8'd0;
        ptime_q[i] <= 32'd0;
      end
    end else if (!oq_stat.stall) begin
      if ((state_q == ST_LVL) && lv_event) begin
        deb_lvl_q[idx_q] <= cur_raw;
        pressed_q[idx_q] <= lv_press;
        tally_q[idx_q]   <= lv_tally;
        if (lv_press) ptime_q[idx_q] <= now_q;
      end else if ((state_q == ST_EVL) && cur_watch) begin
        tally_q[idx_q] <= ev_tally;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q <= now_ms_i;
      raw_q <= pin_levels_i[PINS-1:0];
    end
  end

  bgd_evt_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (oq_ctrl),
    .evt_i       (evt),
    .stat_o      (oq_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_evt_o   (out_evt),
    .out_last_o  (last_o)
  );

  assign pin_index_o   = out_evt.pin;
  assign event_kind_o  = out_evt.kind;
  assign level_o       = out_evt.level;
  assign press_count_o = out_evt.count;

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for button_gesture_detector_core. Millisecond ticks are
// sent through the input channel while a behavioural model of the detector
// predicts every level, repeat, long-press and click event. Each event
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_CYCLES = 40;

  typedef struct packed {
    bgd_pkg::bgd_evt_t ev;
    logic              last;
  } tick_evt_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [2:0]  cfg_idx_i    = 3'd0;
  logic [15:0] cfg_wdata_i  = 16'd0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [31:0] now_ms_i     = 32'd0;
  logic [7:0]  pin_levels_i = 8'hFF;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [2:0]  pin_index_o;
  logic [1:0]  event_kind_o;
  logic        level_o;
  logic [7:0]  press_count_o;
  logic        last_o;

  button_gesture_detector_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .now_ms_i      (now_ms_i),
    .pin_levels_i  (pin_levels_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pin_index_o   (pin_index_o),
    .event_kind_o  (event_kind_o),
    .level_o       (level_o),
    .press_count_o (press_count_o),
    .last_o        (last_o)
  );

  // Detector model: configuration copy and per-pin state.
  logic [7:0]  cfg_watch, cfg_button, cfg_idle;
  logic [15:0] cfg_debounce, cfg_click, cfg_long, cfg_rpt_start, cfg_rpt_intvl;
  logic [7:0]  deb_level, raw_prev, pressed;
  logic [7:0]  tally    [8];
  logic [31:0] press_ts [8];
  logic        deb_pending;
  logic [31:0] deb_start, last_eval;

  tick_evt_t   tick_events[$];
  tick_evt_t   pending_events[$];

  int          errors = 0;
  int          ticks_sent = 0;
  int          events_checked = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [31:0] cur_now = 32'd0;
  logic [7:0]  cur_pins = 8'hFF;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("%0t: timeout, %0d events still expected", $time, pending_events.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void reset_gesture_model();
    cfg_watch     = 8'h00;
    cfg_button    = 8'h00;
    cfg_idle      = bgd_pkg::IDLE_LEVEL_RST;
    cfg_debounce  = bgd_pkg::DEBOUNCE_RST;
    cfg_click     = bgd_pkg::CLICK_WINDOW_RST;
    cfg_long      = bgd_pkg::LONG_PRESS_RST;
    cfg_rpt_start = bgd_pkg::REPEAT_START_RST;
    cfg_rpt_intvl = bgd_pkg::REPEAT_INTVL_RST;
    deb_level     = bgd_pkg::IDLE_LEVEL_RST;
    raw_prev      = bgd_pkg::IDLE_LEVEL_RST;
    pressed       = 8'h00;
    for (int i = 0; i < 8; i++) begin
      tally[i]    = 8'd0;
      press_ts[i] = 32'd0;
    end
    deb_pending = 1'b0;
    deb_start   = 32'd0;
    last_eval   = 32'd0;
  endfunction

  function automatic void log_event(input int pin, input bgd_pkg::bgd_kind_e kind);
    tick_evt_t e;
    e.ev.pin   = 3'(pin);
    e.ev.kind  = kind;
    e.ev.level = deb_level[pin];
    e.ev.count = tally[pin];
    e.last     = 1'b0;
    tick_events.push_back(e);
  endfunction

  // Works out the events that one tick causes and queues them in order.
  function automatic void predict_tick(input logic [31:0] now, input logic [7:0] raw);
    logic [31:0] stable_for;
    logic [31:0] since_eval;
    logic [31:0] held;
    logic        lv;
    logic        btn;
    tick_evt_t   e;
    tick_events.delete();
    if (((raw ^ raw_prev) & cfg_watch) != 8'h00) begin
      deb_pending = 1'b1;
      deb_start   = now;
    end
    raw_prev   = raw;
    stable_for = now - deb_start;
    if (deb_pending && stable_for > 32'(cfg_debounce)) begin
      deb_pending = 1'b0;
      for (int i = 0; i < 8; i++) begin
        lv = raw[i];
        if (cfg_watch[i] && lv != deb_level[i]) begin
          pressed[i] = (lv != cfg_idle[i]);
          if (pressed[i]) begin
            if (tally[i] != 8'hFF) tally[i] = tally[i] + 8'd1;
            press_ts[i] = now;
          end
          deb_level[i] = lv;
          log_event(i, bgd_pkg::EV_LEVEL);
        end
      end
    end
    since_eval = now - last_eval;
    if (since_eval > 32'(cfg_rpt_intvl)) begin
      last_eval = now;
      for (int i = 0; i < 8; i++) begin
        if (cfg_watch[i]) begin
          btn  = cfg_button[i];
          held = now - press_ts[i];
          if (held > 32'(cfg_rpt_start)) begin
            if (pressed[i] && tally[i] == 8'd1) begin
              if (btn) log_event(i, bgd_pkg::EV_REPEAT);
            end else begin
              tally[i] = 8'd0;
            end
          end
          if (held > 32'(cfg_long) && held < 32'(cfg_rpt_start)) begin
            if (!pressed[i] && tally[i] == 8'd1) begin
              if (btn) log_event(i, bgd_pkg::EV_LONG);
              tally[i] = 8'd0;
            end
          end
          if (held > 32'(cfg_click)) begin
            if (!pressed[i] && tally[i] != 8'd0) begin
              if (btn) log_event(i, bgd_pkg::EV_CLICK);
              tally[i] = 8'd0;
            end
          end
        end
      end
    end
    foreach (tick_events[k]) begin
      e      = tick_events[k];
      e.last = (k == tick_events.size() - 1);
      pending_events.push_back(e);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_events
    tick_evt_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      events_checked++;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual %0d/%0d/%0d/%0d/%0d",
                 $time, pin_index_o, event_kind_o, level_o, press_count_o, last_o);
        errors++;
      end else begin
        want = pending_events.pop_front();
        compare_field("pin_index", 32'(want.ev.pin), 32'(pin_index_o));
        compare_field("event_kind", 32'(want.ev.kind), 32'(event_kind_o));
        compare_field("level", 32'(want.ev.level), 32'(level_o));
        compare_field("press_count", 32'(want.ev.count), 32'(press_count_o));
        compare_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  // Valid stays high between back-to-back ticks.
  task automatic send_tick(input logic [31:0] now, input logic [7:0] pins);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    now_ms_i     <= now;
    pin_levels_i <= pins;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_tick(now, pins);
    ticks_sent++;
    cur_now  = now;
    cur_pins = pins;
    @(negedge clk_i);
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_events.size() != 0);
  endtask

  // A tick that causes no event may still be in flight once the queue is
  // empty, so the block is given some extra cycles before any register write.
  task automatic quiesce();
    pause_until_drained();
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      bgd_pkg::REG_WATCH_MASK:   cfg_watch     = data[7:0];
      bgd_pkg::REG_BUTTON_MASK:  cfg_button    = data[7:0];
      bgd_pkg::REG_IDLE_LEVEL:   cfg_idle      = data[7:0];
      bgd_pkg::REG_DEBOUNCE:     cfg_debounce  = data;
      bgd_pkg::REG_CLICK_WINDOW: cfg_click     = data;
      bgd_pkg::REG_LONG_PRESS:   cfg_long      = data;
      bgd_pkg::REG_REPEAT_START: cfg_rpt_start = data;
      bgd_pkg::REG_REPEAT_INTVL: cfg_rpt_intvl = data;
      default: ;
    endcase
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_config(input logic [7:0] watch, input logic [7:0] button,
                             input logic [7:0] idle, input logic [15:0] deb,
                             input logic [15:0] click, input logic [15:0] hold_long,
                             input logic [15:0] rpt_start, input logic [15:0] rpt_intvl);
    write_reg(bgd_pkg::REG_WATCH_MASK, {8'h00, watch});
    write_reg(bgd_pkg::REG_BUTTON_MASK, {8'h00, button});
    write_reg(bgd_pkg::REG_IDLE_LEVEL, {8'h00, idle});
    write_reg(bgd_pkg::REG_DEBOUNCE, deb);
    write_reg(bgd_pkg::REG_CLICK_WINDOW, click);
    write_reg(bgd_pkg::REG_LONG_PRESS, hold_long);
    write_reg(bgd_pkg::REG_REPEAT_START, rpt_start);
    write_reg(bgd_pkg::REG_REPEAT_INTVL, rpt_intvl);
  endtask

  // Mostly well-formed edges that are held past the debounce time, with
  // holds spread across the gesture thresholds, plus bounces and noise.
  task automatic run_ticks(input int n);
    logic [31:0] dt;
    logic [7:0]  flip;
    bit          changed;
    int          pick;
    changed = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) pause_until_drained();
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_tick($urandom, 8'($urandom));
        changed = 1'b0;
      end else if (changed && pick < 80) begin
        dt = 32'(cfg_debounce) + 32'd1 + $urandom_range(0, 2);
        send_tick(cur_now + dt, cur_pins);
        changed = 1'b0;
      end else begin
        flip = 8'h00;
        if ($urandom_range(99) < 45) begin
          if ($urandom_range(1)) flip = 8'h01 << $urandom_range(0, 7);
          else flip = 8'($urandom);
          if ($urandom_range(3) != 0) flip = flip & cfg_watch;
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3: dt = $urandom_range(1, 3);
          4, 5, 6:    dt = $urandom_range(1, 32'(cfg_click) + 20);
          7, 8:       dt = $urandom_range(32'(cfg_long), 32'(cfg_rpt_start) + 50);
          default:    dt = $urandom_range(1, 3000);
        endcase
        changed = ((flip & cfg_watch) != 8'h00);
        send_tick(cur_now + dt, cur_pins ^ flip);
      end
    end
  endtask

  // Nothing is watched after reset, so ticks must pass silently.
  task automatic test_reset_values();
    send_tick(32'd10, 8'h00);
    send_tick(32'd200, 8'h55);
  endtask

  // Reset thresholds: single click, long press on two buttons, repeat while
  // held alongside a watched pin that is not a button, and a double click.
  task automatic test_gestures();
    quiesce();
    write_reg(bgd_pkg::REG_WATCH_MASK, 16'h000F);
    write_reg(bgd_pkg::REG_BUTTON_MASK, 16'h0005);
    send_tick(32'd1000, 8'hFF);
    send_tick(32'd1001, 8'hFE);
    send_tick(32'd1060, 8'hFE);
    send_tick(32'd1100, 8'hFF);
    send_tick(32'd1160, 8'hFF);
    send_tick(32'd1600, 8'hFF);
    send_tick(32'd2000, 8'hFA);
    send_tick(32'd2060, 8'hFA);
    send_tick(32'd3300, 8'hFF);
    send_tick(32'd3360, 8'hFF);
    send_tick(32'd4000, 8'hF6);
    send_tick(32'd4060, 8'hF6);
    send_tick(32'd6200, 8'hF6);
    send_tick(32'd6500, 8'hFF);
    send_tick(32'd6560, 8'hFF);
    send_tick(32'd7000, 8'hFE);
    send_tick(32'd7060, 8'hFE);
    send_tick(32'd7100, 8'hFF);
    send_tick(32'd7160, 8'hFF);
    send_tick(32'd7200, 8'hFE);
    send_tick(32'd7260, 8'hFE);
    send_tick(32'd7300, 8'hFF);
    send_tick(32'd7360, 8'hFF);
    send_tick(32'd7900, 8'hFF);
  endtask

  // The debounce and evaluation timers straddle the 32-bit wrap; the tick that
  // ends the release debounce gives eight level events and eight long presses.
  task automatic test_time_wrap();
    quiesce();
    load_config(8'hFF, 8'hFF, 8'hFF, 16'd20, 16'd40, 16'd100, 16'd200, 16'd10);
    send_tick(32'hFFFF_FFF0, 8'h00);
    send_tick(32'h0000_0008, 8'h00);
    send_tick(32'h0000_0080, 8'hFF);
    send_tick(32'h0000_00A0, 8'hFF);
    send_tick(32'h0000_0200, 8'hFF);
  endtask

  // Ten presses on every pin with no evaluation in between, then one late
  // tick that reports the tally of each pin as a multi-click.
  task automatic test_press_burst();
    logic [31:0] t;
    quiesce();
    load_config(8'hFF, 8'hFF, 8'hFF, 16'd0, 16'd60000, 16'hFFFF, 16'hFFFF, 16'd60000);
    t = cur_now + 32'd100000;
    for (int k = 0; k < 10; k++) begin
      send_tick(t, 8'h00);
      send_tick(t + 32'd1, 8'h00);
      send_tick(t + 32'd2, 8'hFF);
      send_tick(t + 32'd3, 8'hFF);
      t = t + 32'd4;
    end
    send_tick(t + 32'd62000, 8'hFF);
  endtask

  task automatic test_config_extremes();
    quiesce();
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    load_config(8'hFF, 8'hFF, 8'h00, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_ticks(15);
    quiesce();
    load_config(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_ticks(15);
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct);
    quiesce();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    load_config(8'($urandom | $urandom), 8'($urandom), 8'($urandom),
                16'($urandom_range(0, 15)), 16'($urandom_range(10, 120)),
                16'($urandom_range(30, 300)), 16'($urandom_range(0, 600)),
                16'($urandom_range(0, 50)));
    run_ticks(42);
  endtask

  initial begin
    reset_gesture_model();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_gestures();
    test_time_wrap();
    test_press_burst();
    test_config_extremes();
    test_random(0, 0);
    test_random(55, 0);
    test_random(0, 55);
    test_random(36, 36);
    quiesce();
    $display("Sent %0d ticks and checked %0d events: reset thresholds, wrapped time,",
             ticks_sent, events_checked);
    $display("press bursts, extreme registers and random settings under idling.");
    if (errors == 0 && pending_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
